// File: src/mfa_pkg.sv
package mfa_pkg;

    localparam int MOD_W = 30;
    localparam int RAW_W = 64;
    localparam int EXP_W = 63;
    localparam int CMD_W = 3;
    localparam int MP_W = MOD_W + 2;
    localparam int CNT_W = 7;
    localparam int PCNT_W = 6;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(998244353);
    localparam logic [CNT_W-1:0] DIV_SHORT_STEPS = CNT_W'(MOD_W);
    localparam logic [CNT_W-1:0] DIV_RAW_STEPS = CNT_W'(RAW_W);
    localparam logic [CNT_W-1:0] MUL_STEPS = CNT_W'(MP_W);
    localparam logic [PCNT_W-1:0] POW_LAST_BIT = PCNT_W'(EXP_W - 1);
    localparam logic [ADDR_W-1:0] REG_MODULUS = '0;

    typedef enum logic [CMD_W-1:0] {
        CMD_REDUCE   = 3'd0,
        CMD_NEGATE   = 3'd1,
        CMD_ADD      = 3'd2,
        CMD_SUBTRACT = 3'd3,
        CMD_MULTIPLY = 3'd4,
        CMD_DIVIDE   = 3'd5,
        CMD_POWER    = 3'd6,
        CMD_EQUAL    = 3'd7
    } cmd_t;

    typedef enum logic [4:0] {
        OP_IDLE,
        OP_LOAD,
        OP_DEGEN,
        OP_DIV_A,
        OP_DIV_B,
        OP_DIV_RAW,
        OP_DIV_EUC,
        OP_DIV_RUN,
        OP_SAVE_A,
        OP_SAVE_B,
        OP_SAVE_RAW,
        OP_ALU,
        OP_ZERO_DIV,
        OP_MUL_AB,
        OP_MUL_SQ,
        OP_MUL_BASE,
        OP_MUL_INV,
        OP_MUL_RUN,
        OP_SAVE_PROD,
        OP_SAVE_MUL,
        OP_POW_INIT,
        OP_EXP_NEXT,
        OP_SAVE_ACC,
        OP_EUC_INIT,
        OP_EUC_Q,
        OP_EUC_UV,
        OP_SAVE_INV,
        OP_PUBLISH
    } dp_op_t;

    typedef struct packed {
        cmd_t cmd;
        logic degen;
        logic b_zero;
        logic y_zero;
        logic exp_bit;
        logic pow_last;
        logic run_done;
    } dp_status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_RED_A,
        S_RED_A_RUN,
        S_RED_B,
        S_RED_B_RUN,
        S_DISPATCH,
        S_RAW,
        S_RAW_RUN,
        S_MUL,
        S_MUL_RUN,
        S_P_INIT,
        S_P_SQ,
        S_P_SQ_RUN,
        S_P_BASE,
        S_P_BASE_RUN,
        S_P_NEXT,
        S_E_INIT,
        S_E_TEST,
        S_E_DIV_RUN,
        S_E_UV,
        S_E_FIN,
        S_E_FIN_RUN,
        S_PUT
    } state_t;

endpackage

// File: src/mfa_in_if.sv
interface mfa_in_if
    import mfa_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         command;
    logic [MOD_W-1:0]         operand_a;
    logic [MOD_W-1:0]         operand_b;
    logic signed [RAW_W-1:0]  raw_value;
    logic [EXP_W-1:0]         exponent;

    modport source (output valid, command, operand_a, operand_b, raw_value, exponent,
                    input ready);
    modport sink (input valid, command, operand_a, operand_b, raw_value, exponent,
                  output ready);
endinterface

// File: src/mfa_out_if.sv
interface mfa_out_if
    import mfa_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [MOD_W-1:0] result;
    logic             zero_divisor;

    modport source (output valid, result, zero_divisor, input ready);
    modport sink (input valid, result, zero_divisor, output ready);
endinterface

// File: src/mfa_datapath.sv
module mfa_datapath
    import mfa_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  dp_op_t                  op,
    input  logic [MOD_W-1:0]        modulus,
    input  logic [CMD_W-1:0]        command,
    input  logic [MOD_W-1:0]        operand_a,
    input  logic [MOD_W-1:0]        operand_b,
    input  logic signed [RAW_W-1:0] raw_value,
    input  logic [EXP_W-1:0]        exponent,
    output dp_status_t              status,
    output logic [MOD_W-1:0]        result,
    output logic                    zero_divisor
);

    cmd_t                   cmd_reg;
    logic [MOD_W-1:0]       m_reg;
    logic [MOD_W-1:0]       a_in_reg;
    logic [MOD_W-1:0]       b_in_reg;
    logic [RAW_W-1:0]       raw_reg;
    logic [EXP_W-1:0]       e_reg;
    logic [MOD_W-1:0]       a_reg;
    logic [MOD_W-1:0]       b_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [PCNT_W-1:0]      pcnt_reg;
    logic [RAW_W-1:0]       dvd_reg;
    logic [MOD_W-1:0]       rem_reg;
    logic [MOD_W-1:0]       den_reg;
    logic [MOD_W-1:0]       mc_reg;
    logic [MP_W-1:0]        mp_reg;
    logic [MOD_W-1:0]       mm_reg;
    logic [MOD_W-1:0]       acc_reg;
    logic [MOD_W-1:0]       x_reg;
    logic [MOD_W-1:0]       y_reg;
    logic signed [MP_W-1:0] u_reg;
    logic signed [MP_W-1:0] v_reg;
    logic signed [MP_W-1:0] prod_reg;
    logic [MOD_W-1:0]       res_reg;
    logic                   zd_reg;
    logic [MOD_W-1:0]       out_res_reg;
    logic                   out_zd_reg;

    logic [MOD_W:0]         rem_sh;
    logic                   rem_ge;
    logic [MOD_W:0]         rem_sub;
    logic [MOD_W:0]         t1;
    logic [MOD_W:0]         t1_sub;
    logic [MOD_W-1:0]       t1r;
    logic [MOD_W:0]         t2;
    logic [MOD_W:0]         t2_sub;
    logic [MOD_W-1:0]       mm_next;
    logic [MOD_W-1:0]       rem_lo;
    logic [MOD_W-1:0]       mm_neg;
    logic [MOD_W-1:0]       rem_neg;
    logic [MOD_W:0]         sum_ab;
    logic [MOD_W:0]         sum_sub;
    logic [MOD_W:0]         diff_ab;
    logic [MOD_W-1:0]       alu_res;
    logic [MP_W-1:0]        u_mag;
    logic [RAW_W-1:0]       raw_mag;
    logic signed [2*MOD_W+2:0] qv_full;

    // one restoring division step: remainder in rem_reg, quotient bits shift into dvd_reg
    always_comb
    begin
        rem_sh  = {rem_reg, dvd_reg[RAW_W-1]};
        rem_ge  = rem_sh >= {1'b0, den_reg};
        rem_sub = rem_sh - {1'b0, den_reg};
        rem_lo  = rem_reg;
        rem_neg = (rem_lo == '0) ? '0 : m_reg - rem_lo;
    end

    // interleaved modular multiply, multiplier msb first
    always_comb
    begin
        t1      = {mm_reg, 1'b0};
        t1_sub  = t1 - {1'b0, m_reg};
        t1r     = (t1 >= {1'b0, m_reg}) ? t1_sub[MOD_W-1:0] : t1[MOD_W-1:0];
        t2      = {1'b0, t1r} + (mp_reg[MP_W-1] ? {1'b0, mc_reg} : '0);
        t2_sub  = t2 - {1'b0, m_reg};
        mm_next = (t2 >= {1'b0, m_reg}) ? t2_sub[MOD_W-1:0] : t2[MOD_W-1:0];
        mm_neg  = (mm_reg == '0) ? '0 : m_reg - mm_reg;
    end

    always_comb
    begin
        sum_ab  = {1'b0, a_reg} + {1'b0, b_reg};
        sum_sub = sum_ab - {1'b0, m_reg};
        diff_ab = {1'b0, a_reg} + {1'b0, m_reg} - {1'b0, b_reg};
        case (cmd_reg)
            CMD_NEGATE:   alu_res = (a_reg == '0) ? '0 : m_reg - a_reg;
            CMD_ADD:      alu_res = (sum_ab >= {1'b0, m_reg}) ? sum_sub[MOD_W-1:0]
                                                                : sum_ab[MOD_W-1:0];
            CMD_SUBTRACT: alu_res = (a_reg >= b_reg) ? a_reg - b_reg : diff_ab[MOD_W-1:0];
            CMD_EQUAL:    alu_res = (a_reg == b_reg) ? MOD_W'(1) : '0;
            default:      alu_res = '0;
        endcase
        u_mag   = u_reg[MP_W-1] ? MP_W'(-u_reg) : MP_W'(u_reg);
        raw_mag = raw_reg[RAW_W-1] ? (~raw_reg) + RAW_W'(1) : raw_reg;
        qv_full = $signed({1'b0, dvd_reg[MOD_W-1:0]}) * v_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            pcnt_reg <= '0;
        end
        else
        begin
            case (op)
                OP_DIV_A, OP_DIV_B, OP_DIV_EUC: cnt_reg <= DIV_SHORT_STEPS;
                OP_DIV_RAW:                     cnt_reg <= DIV_RAW_STEPS;
                OP_MUL_AB, OP_MUL_SQ, OP_MUL_BASE, OP_MUL_INV: cnt_reg <= MUL_STEPS;
                OP_DIV_RUN, OP_MUL_RUN:         cnt_reg <= cnt_reg - CNT_W'(1);
                OP_POW_INIT:                    pcnt_reg <= POW_LAST_BIT;
                OP_EXP_NEXT:                    pcnt_reg <= pcnt_reg - PCNT_W'(1);
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (op)
            OP_LOAD:
            begin
                cmd_reg  <= cmd_t'(command);
                m_reg    <= modulus;
                a_in_reg <= operand_a;
                b_in_reg <= operand_b;
                raw_reg  <= raw_value;
                e_reg    <= exponent;
            end
            OP_DEGEN:
            begin
                res_reg <= (cmd_reg == CMD_EQUAL) ? MOD_W'(1) : '0;
                zd_reg  <= cmd_reg == CMD_DIVIDE;
            end
            OP_DIV_A:
            begin
                dvd_reg <= {a_in_reg, {(RAW_W-MOD_W){1'b0}}};
                rem_reg <= '0;
                den_reg <= m_reg;
            end
            OP_DIV_B:
            begin
                dvd_reg <= {b_in_reg, {(RAW_W-MOD_W){1'b0}}};
                rem_reg <= '0;
                den_reg <= m_reg;
            end
            OP_DIV_RAW:
            begin
                dvd_reg <= raw_mag;
                rem_reg <= '0;
                den_reg <= m_reg;
            end
            OP_DIV_EUC:
            begin
                dvd_reg <= {x_reg, {(RAW_W-MOD_W){1'b0}}};
                rem_reg <= '0;
                den_reg <= y_reg;
            end
            OP_DIV_RUN:
            begin
                rem_reg <= rem_ge ? rem_sub[MOD_W-1:0] : rem_sh[MOD_W-1:0];
                dvd_reg <= {dvd_reg[RAW_W-2:0], rem_ge};
            end
            OP_SAVE_A: a_reg <= rem_reg;
            OP_SAVE_B: b_reg <= rem_reg;
            OP_SAVE_RAW:
            begin
                res_reg <= raw_reg[RAW_W-1] ? rem_neg : rem_reg;
                zd_reg  <= 1'b0;
            end
            OP_ALU:
            begin
                res_reg <= alu_res;
                zd_reg  <= 1'b0;
            end
            OP_ZERO_DIV:
            begin
                res_reg <= '0;
                zd_reg  <= 1'b1;
            end
            OP_MUL_AB:
            begin
                mc_reg <= a_reg;
                mp_reg <= MP_W'(b_reg);
                mm_reg <= '0;
            end
            OP_MUL_SQ:
            begin
                mc_reg <= acc_reg;
                mp_reg <= MP_W'(acc_reg);
                mm_reg <= '0;
            end
            OP_MUL_BASE:
            begin
                mc_reg <= acc_reg;
                mp_reg <= MP_W'(a_reg);
                mm_reg <= '0;
            end
            OP_MUL_INV:
            begin
                mc_reg <= a_reg;
                mp_reg <= u_mag;
                mm_reg <= '0;
            end
            OP_MUL_RUN:
            begin
                mm_reg <= mm_next;
                mp_reg <= {mp_reg[MP_W-2:0], 1'b0};
            end
            OP_SAVE_PROD:
            begin
                res_reg <= mm_reg;
                zd_reg  <= 1'b0;
            end
            OP_SAVE_MUL: acc_reg <= mm_reg;
            OP_POW_INIT: acc_reg <= MOD_W'(1);
            OP_EXP_NEXT: e_reg <= {e_reg[EXP_W-2:0], 1'b0};
            OP_SAVE_ACC:
            begin
                res_reg <= acc_reg;
                zd_reg  <= 1'b0;
            end
            OP_EUC_INIT:
            begin
                x_reg <= b_reg;
                y_reg <= m_reg;
                u_reg <= MP_W'(1);
                v_reg <= '0;
            end
            OP_EUC_Q:
            begin
                x_reg    <= y_reg;
                y_reg    <= rem_reg;
                prod_reg <= qv_full[MP_W-1:0];
            end
            OP_EUC_UV:
            begin
                u_reg <= v_reg;
                v_reg <= u_reg - prod_reg;
            end
            OP_SAVE_INV:
            begin
                res_reg <= u_reg[MP_W-1] ? mm_neg : mm_reg;
                zd_reg  <= 1'b0;
            end
            OP_PUBLISH:
            begin
                out_res_reg <= res_reg;
                out_zd_reg  <= zd_reg;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        status.cmd      = cmd_reg;
        status.degen    = m_reg < MOD_W'(2);
        status.b_zero   = b_reg == '0;
        status.y_zero   = y_reg == '0;
        status.exp_bit  = e_reg[EXP_W-1];
        status.pow_last = pcnt_reg == '0;
        status.run_done = cnt_reg == '0;
    end

    assign result       = out_res_reg;
    assign zero_divisor = out_zd_reg;

`ifndef SYNTHESIS
    a_div_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        op == OP_DIV_RUN |-> cnt_reg != '0)
        else $error("division stepped past its bit count");
    a_mul_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        op == OP_MUL_RUN |-> cnt_reg != '0)
        else $error("multiply stepped past its bit count");
    a_result_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_PUBLISH && m_reg >= MOD_W'(2)) |=> out_res_reg < m_reg)
        else $error("published result not below modulus");
    a_zd_divide_only: assert property (@(posedge clk) disable iff (!rst_n)
        op == OP_PUBLISH |=> (!out_zd_reg || cmd_reg == CMD_DIVIDE))
        else $error("zero divisor flag outside divide");
`endif

endmodule

// File: src/mfa_controller.sv
module mfa_controller
    import mfa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output dp_op_t     op
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        op             = OP_IDLE;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op         = OP_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status.degen)
                begin
                    op         = OP_DEGEN;
                    state_next = S_PUT;
                end
                else if (status.cmd == CMD_REDUCE)
                    state_next = S_RAW;
                else
                    state_next = S_RED_A;
            end
            S_RED_A:
            begin
                op         = OP_DIV_A;
                state_next = S_RED_A_RUN;
            end
            S_RED_A_RUN:
            begin
                if (status.run_done)
                begin
                    op         = OP_SAVE_A;
                    state_next = S_RED_B;
                end
                else
                    op = OP_DIV_RUN;
            end
            S_RED_B:
            begin
                op         = OP_DIV_B;
                state_next = S_RED_B_RUN;
            end
            S_RED_B_RUN:
            begin
                if (status.run_done)
                begin
                    op         = OP_SAVE_B;
                    state_next = S_DISPATCH;
                end
                else
                    op = OP_DIV_RUN;
            end
            S_DISPATCH:
            begin
                case (status.cmd)
                    CMD_MULTIPLY: state_next = S_MUL;
                    CMD_POWER:    state_next = S_P_INIT;
                    CMD_DIVIDE:
                    begin
                        if (status.b_zero)
                        begin
                            op         = OP_ZERO_DIV;
                            state_next = S_PUT;
                        end
                        else
                            state_next = S_E_INIT;
                    end
                    default:
                    begin
                        op         = OP_ALU;
                        state_next = S_PUT;
                    end
                endcase
            end
            S_RAW:
            begin
                op         = OP_DIV_RAW;
                state_next = S_RAW_RUN;
            end
            S_RAW_RUN:
            begin
                if (status.run_done)
                begin
                    op         = OP_SAVE_RAW;
                    state_next = S_PUT;
                end
                else
                    op = OP_DIV_RUN;
            end
            S_MUL:
            begin
                op         = OP_MUL_AB;
                state_next = S_MUL_RUN;
            end
            S_MUL_RUN:
            begin
                if (status.run_done)
                begin
                    op         = OP_SAVE_PROD;
                    state_next = S_PUT;
                end
                else
                    op = OP_MUL_RUN;
            end
            S_P_INIT:
            begin
                op         = OP_POW_INIT;
                state_next = S_P_SQ;
            end
            S_P_SQ:
            begin
                op         = OP_MUL_SQ;
                state_next = S_P_SQ_RUN;
            end
            S_P_SQ_RUN:
            begin
                if (status.run_done)
                begin
                    op         = OP_SAVE_MUL;
                    state_next = status.exp_bit ? S_P_BASE : S_P_NEXT;
                end
                else
                    op = OP_MUL_RUN;
            end
            S_P_BASE:
            begin
                op         = OP_MUL_BASE;
                state_next = S_P_BASE_RUN;
            end
            S_P_BASE_RUN:
            begin
                if (status.run_done)
                begin
                    op         = OP_SAVE_MUL;
                    state_next = S_P_NEXT;
                end
                else
                    op = OP_MUL_RUN;
            end
            S_P_NEXT:
            begin
                if (status.pow_last)
                begin
                    op         = OP_SAVE_ACC;
                    state_next = S_PUT;
                end
                else
                begin
                    op         = OP_EXP_NEXT;
                    state_next = S_P_SQ;
                end
            end
            S_E_INIT:
            begin
                op         = OP_EUC_INIT;
                state_next = S_E_TEST;
            end
            S_E_TEST:
            begin
                if (status.y_zero)
                    state_next = S_E_FIN;
                else
                begin
                    op         = OP_DIV_EUC;
                    state_next = S_E_DIV_RUN;
                end
            end
            S_E_DIV_RUN:
            begin
                if (status.run_done)
                begin
                    op         = OP_EUC_Q;
                    state_next = S_E_UV;
                end
                else
                    op = OP_DIV_RUN;
            end
            S_E_UV:
            begin
                op         = OP_EUC_UV;
                state_next = S_E_TEST;
            end
            S_E_FIN:
            begin
                op         = OP_MUL_INV;
                state_next = S_E_FIN_RUN;
            end
            S_E_FIN_RUN:
            begin
                if (status.run_done)
                begin
                    op         = OP_SAVE_INV;
                    state_next = S_PUT;
                end
                else
                    op = OP_MUL_RUN;
            end
            S_PUT:
            begin
                // wait for the output slot to drain
                if (!out_valid_reg || out_ready)
                begin
                    op             = OP_PUBLISH;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_publish_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        op == OP_PUBLISH |=> out_valid_reg)
        else $error("publish without output valid");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        op == OP_PUBLISH |-> (!out_valid_reg || out_ready))
        else $error("pending result overwritten");
    a_load_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        op == OP_LOAD |=> state_reg == S_CHECK)
        else $error("load did not start a command");
`endif

endmodule

// File: src/modular_field_alu.sv
// channel   dir  handshake      payload
// in_ch     in   valid/ready    command, operand_a, operand_b, raw_value, exponent
// out_ch    out  valid/ready    result, zero_divisor
// apb       in   psel/penable   paddr, pwdata, prdata (modulus at address 0)
//
// one command at a time; a finished result waits in an output register while
// the next transaction is taken. all work runs on bit-serial units: every command
// but reduce first reduces both operands, reduce divides raw_value, multiply runs
// one product, divide runs one division per euclid step (zero divisor skips it),
// power does 63 squarings plus a multiply per set exponent bit. degenerate modulus
// skips the arithmetic; a held result stalls the unit before the next publish.
// reset is asynchronous; modulus resets to 998244353.
module modular_field_alu
    import mfa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    mfa_in_if.sink            in_ch,
    mfa_out_if.source         out_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [MOD_W-1:0] modulus_reg;
    dp_status_t       status;
    dp_op_t           op;
    logic             sel_modulus;

    assign sel_modulus = paddr[ADDR_W-1:2] == REG_MODULUS[ADDR_W-1:2];
    assign pready      = 1'b1;
    assign prdata      = sel_modulus ? DATA_W'(modulus_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            modulus_reg <= MOD_RESET;
        else if (psel && penable && pwrite && sel_modulus)
            modulus_reg <= pwdata[MOD_W-1:0];
    end

    mfa_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .op        (op)
    );

    mfa_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .modulus      (modulus_reg),
        .command      (in_ch.command),
        .operand_a    (in_ch.operand_a),
        .operand_b    (in_ch.operand_b),
        .raw_value    (in_ch.raw_value),
        .exponent     (in_ch.exponent),
        .status       (status),
        .result       (out_ch.result),
        .zero_divisor (out_ch.zero_divisor)
    );

endmodule
